// File: rtl/core/iida_pkg.sv
`default_nettype none

package iida_pkg;

   // Operation codes carried by req_kind
   typedef enum logic [2:0] {
      KIND_APPEND  = 3'd0,
      KIND_INSERT  = 3'd1,
      KIND_DELETE  = 3'd2,
      KIND_REPLACE = 3'd3,
      KIND_READ    = 3'd4
   } kind_type;

   // Result status codes carried by rsp_status
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Fixed widths of the word fields
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned POS_W   = 7;
   localparam int unsigned COUNT_W = 7;

   // Per-cycle command broadcast to every cell of the row
   typedef struct packed {
      logic write;      // overwrite the cell at the target
      logic shift_up;   // open a gap at the target, load the new word there
      logic shift_down; // close the gap at the target
      logic read;       // capture the word at the target
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/iida_cell.sv
`default_nettype none

module iida_cell
   import iida_pkg::*;
#(
   parameter int unsigned INDEX = 0,
   parameter int unsigned TW    = 7
) (
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic [TW-1:0]     target,
   input  wire logic [DATA_W-1:0] data,
   input  wire logic [DATA_W-1:0] left_value,
   input  wire logic [DATA_W-1:0] right_value,
   output logic      [DATA_W-1:0] value,
   output logic      [DATA_W-1:0] sel_value
);

   localparam logic [TW-1:0] IDX = TW'(INDEX);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic [DATA_W-1:0] sel_ff;
   logic [DATA_W-1:0] sel_in;
   logic              at_target;
   logic              above_target;

   assign at_target    = (IDX == target);
   assign above_target = (IDX > target);

   // Pick the next word: load, take from the left or right neighbor, or hold
   always_comb begin
      value_in = value_ff;
      if (ctl.write && at_target) begin
         value_in = data;
      end else if (ctl.shift_up) begin
         if (at_target) begin
            value_in = data;
         end else if (above_target) begin
            value_in = left_value;
         end
      end else if (ctl.shift_down && (at_target || above_target)) begin
         value_in = right_value;
      end
   end

   // Mask the stored word so the top level can OR the row together
   assign sel_in = (ctl.read && at_target) ? value_ff : '0;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      sel_ff   <= sel_in;
   end

   assign value     = value_ff;
   assign sel_value = sel_ff;

endmodule

`default_nettype wire

// File: rtl/core/indexed_insert_delete_array_unit.sv
`default_nettype none

// Ordered store of signed 32-bit words with a live count, built as a row of
// CAPACITY cells that each hold one entry and trade words with their neighbors.
// Command channel: drive req_kind, req_position and req_data_in with start high;
// the command is taken at the edge where start is high and busy is low. busy
// stays low: every command, including insert and delete, moves the whole row at
// the edge that takes it, so one command per cycle is sustained.
// Result channel: rsp_strobe is high for exactly one cycle, the cycle right
// after the command was taken, with rsp_data_out, rsp_status and rsp_count
// valid in that cycle. The receiver cannot stall; the result is gone after
// that cycle. The read word comes from a per-cell masked register OR-ed
// across the row.
// Bad positions and a full store are reported in rsp_status and change nothing.
// Reset (synchronous, active high) clears the count and the result strobe; the
// stored words are left as they are and are only reachable once rewritten.
module indexed_insert_delete_array_unit
   import iida_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [2:0]                req_kind,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [DATA_W-1:0]  req_data_in,
   output logic                           rsp_strobe,
   output logic signed [DATA_W-1:0]       rsp_data_out,
   output logic [1:0]                     rsp_status,
   output logic [COUNT_W-1:0]             rsp_count
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned TW = (CW > POS_W) ? CW : POS_W;
   localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              rsp_strobe_ff;
   status_type        status_ff;
   status_type        status_in;
   logic [TW-1:0]     count_t;
   logic [TW-1:0]     pos_t;
   logic [TW-1:0]     target;
   logic              full;
   logic              accept;
   cell_ctl_type      ctl;
   logic [DATA_W-1:0] cell_value [CAPACITY];
   logic [DATA_W-1:0] cell_sel   [CAPACITY];
   logic [DATA_W-1:0] read_word;
   logic [TW-1:0]     count_out_t;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign count_t = TW'(count_ff);
   assign pos_t   = TW'(req_position);
   assign full    = (count_t == CAP_T);

   // Decode the command, check bounds and pick the row action
   always_comb begin
      ctl       = '0;
      status_in = ST_DONE;
      count_in  = count_ff;
      target    = pos_t;
      case (req_kind)
         KIND_APPEND: begin
            target = count_t;
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctl.write = 1'b1;
               count_in  = CW'(count_ff + 1'b1);
            end
         end
         KIND_INSERT: begin
            if (pos_t > count_t) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               ctl.shift_up = 1'b1;
               count_in     = CW'(count_ff + 1'b1);
            end
         end
         KIND_DELETE: begin
            if (pos_t >= count_t) begin
               status_in = ST_RANGE;
            end else begin
               ctl.shift_down = 1'b1;
               count_in       = CW'(count_ff - 1'b1);
            end
         end
         KIND_REPLACE: begin
            if (pos_t >= count_t) begin
               status_in = ST_RANGE;
            end else begin
               ctl.write = 1'b1;
            end
         end
         KIND_READ: begin
            if (pos_t >= count_t) begin
               status_in = ST_RANGE;
            end else begin
               ctl.read = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // Drop the action when no command is taken
      if (!accept) begin
         ctl      = '0;
         count_in = count_ff;
      end
   end

   // Build the row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value;
      logic [DATA_W-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_mid_r
         assign right_value = cell_value[i+1];
      end
      iida_cell #(
         .INDEX (i),
         .TW    (TW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .target      (target),
         .data        (req_data_in),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .sel_value   (cell_sel[i])
      );
   end

   // OR the masked cell words; at most one cell is non-zero
   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | cell_sel[i];
      end
   end

   // Hold the count and the result status
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
      if (accept) begin
         status_ff <= status_in;
      end
   end

   assign count_out_t  = TW'(count_ff);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_data_out = read_word;
   assign rsp_status   = status_ff;
   assign rsp_count    = count_out_t[COUNT_W-1:0];

   // A taken command gives exactly one result in the next cycle
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("result strobe missing after a taken command");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result strobe without a taken command");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_t <= CAP_T)
      else $error("live count exceeds capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && status_ff == ST_FULL) |-> full)
      else $error("full status reported with room left");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && status_ff != ST_DONE) |-> (rsp_data_out == '0))
      else $error("refused command returned a nonzero word");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("live count moved without a command");

endmodule

`default_nettype wire
